/* rtl/multichannel_moving_average_core_macros.svh */
// Assertion macros for the moving average core
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MMA_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);
`else
`define MMA_ASSERT(label, prop, msg)
`define MMA_ASSERT_NEXT(label, cause, effect, msg)
`endif
`endif

/* rtl/mma_pkg.sv */
// Shared constants and control and status types of the moving average core
package mma_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int CHANNELS     = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int CHANNEL_BITS = 3;
    localparam int LENGTH_BITS  = 7;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 7'd4;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic ram_we;
        logic out_load;
    } back_stat_t;

endpackage

/* rtl/mma_if.sv */
// Stream interfaces for samples in and averages out
interface mma_sample_if #(
    parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic [mma_pkg::CHANNEL_BITS-1:0]     channel;
    logic signed [SAMPLE_BITS-1:0]        sample;
    logic                                 restart;

    modport source (output valid, channel, sample, restart, input ready);
    modport sink   (input valid, channel, sample, restart, output ready);
endinterface

interface mma_average_if #(
    parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic [mma_pkg::CHANNEL_BITS-1:0]     result_channel;
    logic signed [SAMPLE_BITS-1:0]        average;

    modport source (output valid, result_channel, average, input ready);
    modport sink   (input valid, result_channel, average, output ready);
endinterface

/* rtl/mma_ram.sv */
// Generic simple dual-port RAM with registered read
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/mma_queue.sv */
// Short FIFO between the front and back parts
module mma_queue #(
    parameter int WIDTH = 20,
    parameter int DEPTH = mma_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mma_pkg::q_ctrl_t ctrl,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data,
    output mma_pkg::q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (ctrl.pop)
            begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            count_reg <= count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = data_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* rtl/mma_front.sv */
// Front part: accept samples, drop unknown channels, pack queue entries
module mma_front #(
    parameter int CHANNELS    = mma_pkg::CHANNELS,
    parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS
) (
    mma_sample_if.sink                                       samples,
    input  mma_pkg::q_stat_t                                 q_stat,
    output logic                                             push,
    output logic [mma_pkg::CHANNEL_BITS+SAMPLE_BITS:0]       entry
);

    logic in_range;

    assign in_range      = (32'(samples.channel) < CHANNELS);
    assign samples.ready = !q_stat.full;
    assign push          = samples.valid && !q_stat.full && in_range;
    assign entry         = {samples.channel, samples.sample, samples.restart};

endmodule

/* rtl/mma_back.sv */
// Back part: window store update, running sum and serial divide
module mma_back #(
    parameter int MAX_WINDOW  = mma_pkg::MAX_WINDOW,
    parameter int CHANNELS    = mma_pkg::CHANNELS,
    parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          clear,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]               len,
    input  mma_pkg::q_stat_t                              q_stat,
    output logic                                          pop,
    input  logic [mma_pkg::CHANNEL_BITS+SAMPLE_BITS:0]    q_data,
    mma_average_if.source                                 averages,
    output mma_pkg::back_stat_t                           stat
);

    localparam int ENTRY_W = mma_pkg::CHANNEL_BITS + SAMPLE_BITS + 1;
    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH   = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t                        state_reg;
    logic [CH_W-1:0]               ch_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          restart_reg;

    logic signed [SUM_W-1:0]       sum_reg  [CHANNELS];
    logic [LEN_W-1:0]              fill_reg [CHANNELS];
    logic [PTR_W-1:0]              wp_reg   [CHANNELS];

    logic signed [SUM_W-1:0]       acc_reg;
    logic [LEN_W-1:0]              cur_fill_reg;
    logic [PTR_W-1:0]              cur_wp_reg;
    logic                          full_reg;

    logic [SUM_W-1:0]              quo_reg;
    logic [LEN_W-1:0]              rem_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          neg_reg;

    logic                          out_valid_reg;
    logic [mma_pkg::CHANNEL_BITS-1:0] out_channel_reg;
    logic signed [SAMPLE_BITS-1:0] out_average_reg;

    logic signed [SUM_W-1:0]       cur_sum;
    logic [LEN_W-1:0]              cur_fill;
    logic [PTR_W-1:0]              cur_wp;
    logic [LEN_W:0]                wp_ext;
    logic [LEN_W:0]                len_ext;
    logic [PTR_W-1:0]              old_pos;

    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [SUM_W-1:0]       new_sum;
    logic [LEN_W-1:0]              new_fill;
    logic [PTR_W-1:0]              new_wp;
    logic                          emit;

    logic [LEN_W:0]                trial;
    logic                          trial_ge;
    logic [SUM_W-1:0]              quo_signed;
    logic                          out_free;

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [CH_W-1:0]  ch,
        input logic [PTR_W-1:0] pos
    );
        return ADDR_W'(32'(ch) * MAX_WINDOW + 32'(pos));
    endfunction

    always_comb
    begin
        cur_sum  = restart_reg ? '0 : sum_reg[ch_reg];
        cur_fill = restart_reg ? '0 : fill_reg[ch_reg];
        cur_wp   = restart_reg ? '0 : wp_reg[ch_reg];
        wp_ext   = (LEN_W+1)'(cur_wp);
        len_ext  = (LEN_W+1)'(len);
        if (wp_ext >= len_ext)
        begin
            old_pos = PTR_W'(wp_ext - len_ext);
        end
        else
        begin
            old_pos = PTR_W'(wp_ext + (LEN_W+1)'(MAX_WINDOW) - len_ext);
        end
    end

    assign old_sample = ram_rdata;

    always_comb
    begin
        new_sum  = acc_reg - (full_reg ? SUM_W'(old_sample) : '0) + SUM_W'(sample_reg);
        new_fill = full_reg ? cur_fill_reg : cur_fill_reg + 1'b1;
        new_wp   = (cur_wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : cur_wp_reg + 1'b1;
        emit     = (new_fill >= len);
    end

    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge   = (trial >= len_ext);
    assign quo_signed = neg_reg ? -quo_reg : quo_reg;
    assign out_free   = !out_valid_reg || averages.ready;

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty;

    mma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (state_reg == ST_UPDATE),
        .waddr (slot_addr(ch_reg, cur_wp_reg)),
        .wdata (sample_reg),
        .re    (state_reg == ST_LOOKUP),
        .raddr (slot_addr(ch_reg, old_pos)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ch_reg          <= '0;
            sample_reg      <= '0;
            restart_reg     <= 1'b0;
            acc_reg         <= '0;
            cur_fill_reg    <= '0;
            cur_wp_reg      <= '0;
            full_reg        <= 1'b0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            neg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            out_average_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                fill_reg[i] <= '0;
                wp_reg[i]   <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && averages.ready && (state_reg != ST_DELIVER))
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    sum_reg[i]  <= '0;
                    fill_reg[i] <= '0;
                    wp_reg[i]   <= '0;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        ch_reg      <= CH_W'(q_data[ENTRY_W-1 -: mma_pkg::CHANNEL_BITS]);
                        sample_reg  <= q_data[SAMPLE_BITS:1];
                        restart_reg <= q_data[0];
                        state_reg   <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    acc_reg      <= cur_sum;
                    cur_fill_reg <= cur_fill;
                    cur_wp_reg   <= cur_wp;
                    full_reg     <= (cur_fill >= len);
                    state_reg    <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (!clear)
                    begin
                        sum_reg[ch_reg]  <= new_sum;
                        fill_reg[ch_reg] <= new_fill;
                        wp_reg[ch_reg]   <= new_wp;
                    end
                    neg_reg          <= new_sum[SUM_W-1];
                    quo_reg          <= new_sum[SUM_W-1] ? -new_sum : new_sum;
                    rem_reg          <= '0;
                    cnt_reg          <= '0;
                    state_reg        <= emit ? ST_DIVIDE : ST_IDLE;
                end
                ST_DIVIDE:
                begin
                    rem_reg <= trial_ge ? LEN_W'(trial - len_ext) : LEN_W'(trial);
                    quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_channel_reg <= mma_pkg::CHANNEL_BITS'(ch_reg);
                        out_average_reg <= quo_signed[SAMPLE_BITS-1:0];
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign averages.valid          = out_valid_reg;
    assign averages.result_channel = out_channel_reg;
    assign averages.average        = out_average_reg;

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.ram_we   = (state_reg == ST_UPDATE);
    assign stat.out_load = (state_reg == ST_DELIVER) && out_free;

endmodule

/* rtl/multichannel_moving_average_core.sv */
// Top level of the multichannel moving average core
//
//   port       | dir  | carries
//   -----------+------+----------------------------------------------
//   samples    | sink | channel, sample (Q8.8), restart
//   averages   | src  | result_channel, average (Q8.8)
//   cfg_we/wd  | sink | window_length
//
// An item that yields an average goes through lookup, update, the serial
// one-bit-a-cycle divider and delivery; one that yields none ends at update.
// A two-entry queue lets samples transfer while the back part works.
// Reset clears window length to 4 and every channel's sum, fill and position.
// The window store needs no clearing; a stalled average holds in its register.
`include "multichannel_moving_average_core_macros.svh"

module multichannel_moving_average_core #(
    parameter int MAX_WINDOW  = mma_pkg::MAX_WINDOW,
    parameter int CHANNELS    = mma_pkg::CHANNELS,
    parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mma_pkg::LENGTH_BITS-1:0]   cfg_wdata,
    mma_sample_if.sink                        samples,
    mma_average_if.source                     averages
);

    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int ENTRY_W = mma_pkg::CHANNEL_BITS + SAMPLE_BITS + 1;

    logic [mma_pkg::LENGTH_BITS-1:0] window_length_reg;
    logic [LEN_W-1:0]                len_eff;
    logic [ENTRY_W-1:0]              q_wr_data;
    logic [ENTRY_W-1:0]              q_rd_data;
    mma_pkg::q_ctrl_t                q_ctrl;
    mma_pkg::q_stat_t                q_stat;
    mma_pkg::back_stat_t             bstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= mma_pkg::LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            window_length_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (window_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(window_length_reg) > MAX_WINDOW)
        begin
            len_eff = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = LEN_W'(window_length_reg);
        end
    end

    mma_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .samples (samples),
        .q_stat  (q_stat),
        .push    (q_ctrl.push),
        .entry   (q_wr_data)
    );

    mma_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (mma_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (q_ctrl),
        .wr_data (q_wr_data),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    mma_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_we),
        .len      (len_eff),
        .q_stat   (q_stat),
        .pop      (q_ctrl.pop),
        .q_data   (q_rd_data),
        .averages (averages),
        .stat     (bstat)
    );

    `MMA_ASSERT(a_pop_nonempty, q_ctrl.pop |-> !q_stat.empty, "pop from an empty queue")
    `MMA_ASSERT(a_pop_idle, q_ctrl.pop |-> !bstat.busy, "pop while back part busy")
    `MMA_ASSERT(a_no_overwrite, bstat.out_load |-> !(averages.valid && !averages.ready), "stalled average overwritten")
    `MMA_ASSERT_NEXT(a_push_lands, q_ctrl.push && !q_ctrl.pop, !q_stat.empty, "pushed entry lost")
    `MMA_ASSERT_NEXT(a_single_write, bstat.ram_we, !bstat.ram_we, "store written twice for one item")

endmodule
